### design/v4n_pkg.sv
// ----------------------------------------------------------------------------
// v4n_pkg
// Shared widths and constants for the four-component vector normalizer.
// ----------------------------------------------------------------------------
package v4n_pkg;

   localparam int NUM_LANES   = 4;
   localparam int COMP_W      = 16;                 // Q8.8 component
   localparam int UNIT_W      = 16;                 // Q1.14 result
   localparam int MAG_W       = 17;                 // floor root, Q8.8
   localparam int SQ_W        = 2 * COMP_W;         // one square
   localparam int SUM_W       = SQ_W + 1;           // sum of four squares
   localparam int SQRT_STAGES = MAG_W;              // one root bit per stage
   localparam int QUOT_W      = 15;                 // quotient never exceeds 2^14
   localparam int FRAC_SHIFT  = QUOT_W - 1;         // scale by 16384
   localparam int DIVD_W      = COMP_W + FRAC_SHIFT;
   localparam logic [QUOT_W-1:0] UNIT_ONE = QUOT_W'(1 << FRAC_SHIFT);

   typedef logic [COMP_W-1:0] mag_type;
   typedef logic [MAG_W-1:0]  len_type;
   typedef logic [QUOT_W-1:0] quot_type;

endpackage

### design/v4n_square_lane.sv
// ----------------------------------------------------------------------------
// v4n_square_lane
// Registers magnitude, sign and square of one component.
// ----------------------------------------------------------------------------
module v4n_square_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [v4n_pkg::COMP_W-1:0] comp,
   output v4n_pkg::mag_type              mag,
   output logic                          sign,
   output logic [v4n_pkg::SQ_W-1:0]      square
);
   import v4n_pkg::*;

   mag_type           mag_in, mag_ff;
   logic              sign_ff;
   logic [SQ_W-1:0]   sq_ff;

   // -32768 maps to 32768, which fits the unsigned width
   assign mag_in = comp[COMP_W-1] ? mag_type'(-comp) : mag_type'(comp);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff  <= mag_in;
         sign_ff <= comp[COMP_W-1];
         sq_ff   <= SQ_W'(mag_in) * SQ_W'(mag_in);
      end
   end

   assign mag    = mag_ff;
   assign sign   = sign_ff;
   assign square = sq_ff;

endmodule

### design/v4n_sqrt.sv
// ----------------------------------------------------------------------------
// v4n_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module v4n_sqrt (
   input  logic                       clock,
   input  logic                       en,
   input  logic [v4n_pkg::SUM_W-1:0]  radicand,
   output v4n_pkg::len_type           root
);
   import v4n_pkg::*;

   localparam int RAD_W = 2 * SQRT_STAGES;
   localparam int REM_W = MAG_W + 3;

   logic [REM_W-1:0] rem_ff  [SQRT_STAGES-1];
   len_type          root_ff [SQRT_STAGES];
   logic [RAD_W-1:0] rad_ff  [SQRT_STAGES-1];

   genvar k;
   generate
      for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
         logic [REM_W-1:0] rem_prev, rem_sh, trial;
         len_type          root_prev;
         logic [RAD_W-1:0] rad_prev;
         logic             ge;

         if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = RAD_W'(radicand);
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign root_prev = root_ff[k-1];
            assign rad_prev  = rad_ff[k-1];
         end

         assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1:RAD_W-2]};
         assign trial  = {1'b0, root_prev, 2'b01};
         assign ge     = (rem_sh >= trial);

         always_ff @(posedge clock) begin
            if (en) begin
               root_ff[k] <= {root_prev[MAG_W-2:0], ge};
            end
         end

         // last stage only needs the root bit
         if (k < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k] <= ge ? (rem_sh - trial) : rem_sh;
                  rad_ff[k] <= {rad_prev[RAD_W-3:0], 2'b00};
               end
            end
         end
      end
   endgenerate

   assign root = root_ff[SQRT_STAGES-1];

endmodule

### design/v4n_div_lane.sv
// ----------------------------------------------------------------------------
// v4n_div_lane
// Pipelined restoring divide of (mag << 14) by the length, saturated to 2^14.
// ----------------------------------------------------------------------------
module v4n_div_lane (
   input  logic               clock,
   input  logic               en,
   input  v4n_pkg::mag_type   mag,
   input  v4n_pkg::len_type   len,
   output v4n_pkg::quot_type  quot
);
   import v4n_pkg::*;

   localparam int CMP_W = MAG_W + QUOT_W;

   logic [DIVD_W-1:0] rem_ff  [QUOT_W-1];
   len_type           len_ff  [QUOT_W-1];
   quot_type          q_ff    [QUOT_W];

   genvar k;
   generate
      for (k = 0; k < QUOT_W; k++) begin : g_stage
         logic [DIVD_W-1:0] rem_prev;
         len_type           len_prev;
         quot_type          q_prev;
         logic [CMP_W-1:0]  divs;
         logic              ge;

         if (k == 0) begin : g_first
            assign rem_prev = {mag, FRAC_SHIFT'(0)};
            assign len_prev = len;
            assign q_prev   = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign len_prev = len_ff[k-1];
            assign q_prev   = q_ff[k-1];
         end

         assign divs = CMP_W'(len_prev) << (QUOT_W - 1 - k);
         assign ge   = (CMP_W'(rem_prev) >= divs);

         always_ff @(posedge clock) begin
            if (en) begin
               q_ff[k] <= {q_prev[QUOT_W-2:0], ge};
            end
         end

         // last stage only needs the quotient bit
         if (k < QUOT_W - 1) begin : g_carry
            always_ff @(posedge clock) begin
               if (en) begin
                  rem_ff[k] <= ge ? (rem_prev - divs[DIVD_W-1:0]) : rem_prev;
                  len_ff[k] <= len_prev;
               end
            end
         end
      end
   endgenerate

   assign quot = (q_ff[QUOT_W-1] > UNIT_ONE) ? UNIT_ONE : q_ff[QUOT_W-1];

endmodule

### design/vec4_normalize_core.sv
// ----------------------------------------------------------------------------
// vec4_normalize_core
// From req transfer to rsp_tvalid: square, sum, 17 root stages, 15 divide
// stages, output register. Throughput: one vector per cycle while the output
// is not stalled, set by the fully pipelined root and the four divide lanes.
// The whole pipeline advances only when the output register can take data.
// Reset clears the valid bits only; no state carries between vectors.
// ----------------------------------------------------------------------------
module vec4_normalize_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // comp_x[15:0], comp_y, comp_z, comp_w
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // unit_x[15:0], unit_y, unit_z, unit_w,
                                    // magnitude[16:0], zero pad
   output logic [0:0]  rsp_tuser    // zero_length
);
   import v4n_pkg::*;

   // pipeline depth ahead of the output register
   localparam int MAG_DLY  = 1 + SQRT_STAGES;      // sum stage plus root
   localparam int LEN_DLY  = QUOT_W;               // divide lanes
   localparam int SIGN_DLY = MAG_DLY + LEN_DLY;
   localparam int PIPE_LEN = 1 + SIGN_DLY;         // square stage in front

   logic en;

   // valid bit per stage; whole pipe stalls on output backpressure
   logic vld_ff [PIPE_LEN];
   logic rsp_valid_ff;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // square lanes
   mag_type           sq_mag  [NUM_LANES];
   logic              sq_sign [NUM_LANES];
   logic [SQ_W-1:0]   sq_val  [NUM_LANES];

   genvar l;
   generate
      for (l = 0; l < NUM_LANES; l++) begin : g_sq
         v4n_square_lane u_sq (
            .clock  (clock),
            .en     (en),
            .comp   (req_tdata[l*COMP_W +: COMP_W]),
            .mag    (sq_mag[l]),
            .sign   (sq_sign[l]),
            .square (sq_val[l])
         );
      end
   endgenerate

   // merge: sum of squares
   logic [SUM_W-1:0] sum_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= SUM_W'(sq_val[0]) + SUM_W'(sq_val[1])
                 + SUM_W'(sq_val[2]) + SUM_W'(sq_val[3]);
      end
   end

   len_type root;
   v4n_sqrt u_sqrt (
      .clock    (clock),
      .en       (en),
      .radicand (sum_ff),
      .root     (root)
   );

   // side data delayed to meet the root and the quotients
   mag_type mag_dly_ff  [MAG_DLY][NUM_LANES];
   logic    sign_dly_ff [SIGN_DLY][NUM_LANES];
   len_type len_dly_ff  [LEN_DLY];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            mag_dly_ff[0][i]  <= sq_mag[i];
            sign_dly_ff[0][i] <= sq_sign[i];
            for (int s = 1; s < MAG_DLY; s++)  mag_dly_ff[s][i]  <= mag_dly_ff[s-1][i];
            for (int s = 1; s < SIGN_DLY; s++) sign_dly_ff[s][i] <= sign_dly_ff[s-1][i];
         end
         len_dly_ff[0] <= root;
         for (int s = 1; s < LEN_DLY; s++) len_dly_ff[s] <= len_dly_ff[s-1];
      end
   end

   // divide lanes
   quot_type quot [NUM_LANES];
   generate
      for (l = 0; l < NUM_LANES; l++) begin : g_div
         v4n_div_lane u_div (
            .clock (clock),
            .en    (en),
            .mag   (mag_dly_ff[MAG_DLY-1][l]),
            .len   (root),
            .quot  (quot[l])
         );
      end
   endgenerate

   // output register: sign restore, zero-length override
   logic [UNIT_W-1:0] unit_ff [NUM_LANES];
   logic [UNIT_W-1:0] unit_in [NUM_LANES];
   len_type           len_ff;
   logic              zero_ff, zero_in;

   assign zero_in = (len_dly_ff[LEN_DLY-1] == '0);

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         if (zero_in) begin
            unit_in[i] = '0;
         end else if (sign_dly_ff[SIGN_DLY-1][i]) begin
            unit_in[i] = UNIT_W'(-UNIT_W'(quot[i]));
         end else begin
            unit_in[i] = UNIT_W'(quot[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NUM_LANES; i++) unit_ff[i] <= unit_in[i];
         len_ff  <= len_dly_ff[LEN_DLY-1];
         zero_ff <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < PIPE_LEN; s++) vld_ff[s] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= req_tvalid;
         for (int s = 1; s < PIPE_LEN; s++) vld_ff[s] <= vld_ff[s-1];
         rsp_valid_ff <= vld_ff[PIPE_LEN-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, len_ff, unit_ff[3], unit_ff[2], unit_ff[1], unit_ff[0]};
   assign rsp_tuser  = zero_ff;

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for vec4_normalize_core: a queue-fed driver, a monitor
// that checks each rsp transfer against a predicted unit vector and length,
// and several idle and stall phases, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import v4n_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 35;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] ux, uy, uz, uw;
      logic [16:0] mag;
      logic        zero;
   } unit_vec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // comp_x, comp_y, comp_z, comp_w
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;        // unit_x, unit_y, unit_z, unit_w, magnitude, pad
   logic [0:0]  rsp_tuser;        // zero_length

   logic [63:0]  vec_pending[$];
   unit_vec_type unit_expected[$];
   int           errors = 0;
   int           cycles = 0;
   int           checked = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           hold_cycles = 0;
   bit           req_taken = 0;

   vec4_normalize_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // integer floor root, bitwise method
   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 32;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] scale_lane(logic signed [15:0] c, longint unsigned len);
      longint unsigned m, q;
      m = (c < 0) ? longint'(-int'(c)) : longint'(c);
      q = (m * 16384) / len;
      if (q > 16384) q = 16384;
      return (c < 0) ? 16'(-q) : 16'(q);
   endfunction

   function automatic unit_vec_type normalize(logic [63:0] v);
      unit_vec_type r;
      logic signed [15:0] c[4];
      longint unsigned sum, len;
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         c[i] = v[16*i +: 16];
         sum += longint'(int'(c[i]) * int'(c[i]));
      end
      len = isqrt(sum);
      r = '0;
      if (len == 0) begin
         r.zero = 1'b1;
      end else begin
         r.ux = scale_lane(c[0], len);
         r.uy = scale_lane(c[1], len);
         r.uz = scale_lane(c[2], len);
         r.uw = scale_lane(c[3], len);
         r.mag = 17'(len);
      end
      return r;
   endfunction

   function automatic logic [15:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 15)) - 16'd8;          // near zero
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;  // extremes
         default: return 16'($urandom);
      endcase
   endfunction

   // req transfers are taken at the rising edge
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         unit_expected.push_back(normalize(req_tdata));
         void'(vec_pending.pop_front());
      end
   end

   // driver: inputs change at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (vec_pending.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= vec_pending[0];
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver ready, with its own hold-off counter
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > recv_stall_pct);
      end
   end

   // monitor: sampled at the rising edge
   always @(posedge clock) begin
      unit_vec_type exp_v, got;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[63:0] == 64'h0 ? 64'h0 : {rsp_tdata[15:0], rsp_tdata[31:16],
                rsp_tdata[47:32], rsp_tdata[63:48]}, rsp_tdata[80:64], rsp_tuser[0]};
         if (unit_expected.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors <= errors + 1;
         end else begin
            exp_v = unit_expected.pop_front();
            checked <= checked + 1;
            if (got !== exp_v) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_v, got);
               errors <= errors + 1;
            end
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic run_phase(int n, int idle, int stall);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < n; i++) vec_pending.push_back({rand_comp(), rand_comp(),
                                                         rand_comp(), rand_comp()});
      while (vec_pending.size() != 0 || req_tvalid) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      // directed: zero, extremes, single axes, floor-root clamp cases
      vec_pending.push_back(64'h0);
      vec_pending.push_back({4{16'h8000}});
      vec_pending.push_back({4{16'h7FFF}});
      vec_pending.push_back({48'h0, 16'h0001});
      vec_pending.push_back({48'h0, 16'hFFFF});
      vec_pending.push_back({16'h8000, 48'h0});
      vec_pending.push_back({16'h0001, 16'h0001, 16'h0001, 16'h0001});
      vec_pending.push_back({16'h0, 16'h0, 16'h0001, 16'h0001});   // root floors to 1
      vec_pending.push_back({16'h0, 16'h0, 16'hFFFF, 16'h0002});
      vec_pending.push_back({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      vec_pending.push_back({16'h0003, 16'hFFFD, 16'h0004, 16'hFFFC});
      vec_pending.push_back({16'h5555, 16'hAAAA, 16'h0F0F, 16'hF0F0});
      run_phase(0, 0, 0);
      run_phase(300, 0, 0);
      run_phase(280, 62, 0);
      run_phase(280, 0, 62);
      // long hold-off while the sender keeps offering: pipeline fills
      hold_cycles = 200;
      run_phase(120, 0, 0);
      run_phase(170, 14, 14);
      while (unit_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Checked %0d vectors across unthrottled, idle, stall and hold-off phases",
               checked);
      if (errors == 0 && unit_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
